/* rtl/mngp_pkg.sv */
// package for the midi note grid parser
// holds result kinds, error codes, config indices and the front-to-back request type; no dependencies
`timescale 1ns / 1ps
package mngp_pkg;

    localparam logic [1:0] KIND_NOTE  = 2'd0;
    localparam logic [1:0] KIND_ERROR = 2'd1;
    localparam logic [1:0] KIND_DONE  = 2'd2;

    localparam logic [3:0] ERR_NONE      = 4'd0;
    localparam logic [3:0] ERR_HDR_TAG   = 4'd1;
    localparam logic [3:0] ERR_HDR_LEN   = 4'd2;
    localparam logic [3:0] ERR_FORMAT    = 4'd3;
    localparam logic [3:0] ERR_NTRK      = 4'd4;
    localparam logic [3:0] ERR_ZERO_DIV  = 4'd5;
    localparam logic [3:0] ERR_TRK_TAG   = 4'd6;
    localparam logic [3:0] ERR_LONG      = 4'd7;
    localparam logic [3:0] ERR_VELOCITY  = 4'd8;
    localparam logic [3:0] ERR_EOT       = 4'd9;
    localparam logic [3:0] ERR_META      = 4'd10;
    localparam logic [3:0] ERR_STATUS    = 4'd11;
    localparam logic [3:0] ERR_TRUNCATED = 4'd12;

    localparam logic [1:0] CFG_KEY_TOP   = 2'd0;
    localparam logic [1:0] CFG_ROW_COUNT = 2'd1;
    localparam logic [1:0] CFG_STEPS     = 2'd2;

    // request from parser to result unit; tick/division widths fixed at maximum
    typedef struct packed {
        logic [1:0]  kind;
        logic [6:0]  row;
        logic [39:0] ticks;
        logic [15:0] division;
        logic [4:0]  steps;
        logic [7:0]  track;
        logic [3:0]  code;
    } t_req;

endpackage

/* rtl/midi_note_grid_parser.sv */
// midi note grid parser top level: config registers, parser, queue, result unit
// depends on mngp_pkg, mngp_front, mngp_queue, mngp_back
// the parser decodes bytes in order; a note is divided over TICK_BITS+5 numerator bits in the result unit,
// while other results go straight to its output state after the queue
// throughput: one byte per cycle, stalling while the queue is full behind a divide or a stalled output
// synchronous active-low reset restores register defaults and the header state
`timescale 1ns / 1ps
module midi_note_grid_parser
    import mngp_pkg::*;
#(
    parameter int COLUMN_BITS = 16,
    parameter int TICK_BITS   = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // data_byte
    input  logic        s_axis_tlast,   // end_of_file
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // note_row, note_column, track_number, error_code
    output logic [1:0]  m_axis_tuser,   // result_kind
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data
);

    logic [6:0] r_key_top;
    logic [7:0] r_row_count;
    logic [4:0] r_steps;
    logic       f_valid, f_ready, q_valid, q_ready;
    t_req       f_req, q_req;
    logic [6:0] row;
    logic [15:0] col;
    logic [7:0] trk;
    logic [3:0] code;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_top <= 7'd95; r_row_count <= 8'd60; r_steps <= 5'd4;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_KEY_TOP:   r_key_top   <= i_cfg_data[6:0];
                CFG_ROW_COUNT: r_row_count <= i_cfg_data;
                CFG_STEPS:     r_steps     <= i_cfg_data[4:0];
                default: ;
            endcase
        end
    end

    mngp_front #(.TICK_BITS(TICK_BITS)) u_front (
        .i_clk, .i_rst_n,
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_byte(s_axis_tdata), .i_last(s_axis_tlast),
        .i_key_top(r_key_top), .i_row_count(r_row_count), .i_steps(r_steps),
        .o_req_valid(f_valid), .i_req_ready(f_ready), .o_req(f_req)
    );

    mngp_queue u_queue (
        .i_clk, .i_rst_n,
        .i_valid(f_valid), .o_ready(f_ready), .i_data(f_req),
        .o_valid(q_valid), .i_ready(q_ready), .o_data(q_req)
    );

    mngp_back #(.COLUMN_BITS(COLUMN_BITS), .TICK_BITS(TICK_BITS)) u_back (
        .i_clk, .i_rst_n,
        .i_valid(q_valid), .o_ready(q_ready), .i_req(q_req),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready),
        .o_kind(m_axis_tuser), .o_row(row), .o_col(col), .o_track(trk), .o_code(code)
    );

    assign m_axis_tdata = {5'd0, code, trk, col, row};

endmodule

/* rtl/mngp_front.sv */
// byte parser: header, track and event decoding, emits note/error/done requests
// depends on mngp_pkg
`timescale 1ns / 1ps
module mngp_front
    import mngp_pkg::*;
#(
    parameter int TICK_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_byte,
    input  logic        i_last,
    input  logic [6:0]  i_key_top,
    input  logic [7:0]  i_row_count,
    input  logic [4:0]  i_steps,
    output logic        o_req_valid,
    input  logic        i_req_ready,
    output t_req        o_req
);

    typedef enum logic [16:0] {
        ST_HDR_TAG  = 17'h00001,
        ST_HDR_LEN  = 17'h00002,
        ST_HDR_FMT  = 17'h00004,
        ST_HDR_NTRK = 17'h00008,
        ST_HDR_DIV  = 17'h00010,
        ST_TRK_TAG  = 17'h00020,
        ST_TRK_LEN  = 17'h00040,
        ST_DELTA    = 17'h00080,
        ST_STATUS   = 17'h00100,
        ST_DATA1    = 17'h00200,
        ST_NOTE_VEL = 17'h00400,
        ST_VEL_CHK  = 17'h00800,
        ST_SKIP1    = 17'h01000,
        ST_META     = 17'h02000,
        ST_EOT_LEN  = 17'h04000,
        ST_LEN      = 17'h08000,
        ST_SKIP     = 17'h10000
    } t_state;

    localparam logic [TICK_BITS-1:0] TMAX = '1;
    localparam int SUM_BITS = ((TICK_BITS > 28) ? TICK_BITS : 28) + 1;

    t_state r_state, n_state;
    logic [2:0]  r_cnt, n_cnt;
    logic [27:0] r_acc, n_acc;
    logic [15:0] r_div, n_div;
    logic [TICK_BITS-1:0] r_tick, n_tick;
    logic [7:0]  r_ntrk, n_ntrk;
    logic [7:0]  r_tdone, n_tdone;
    logic [6:0]  r_note, n_note;
    logic [3:0]  r_evk, n_evk;
    logic        r_stop, n_stop;

    logic        emit;
    t_req        req;
    logic [7:0]  ref_b;
    logic [27:0] acc_sh;
    logic [SUM_BITS-1:0] tsum;
    logic [7:0]  row8;

    assign o_ready     = i_req_ready;
    assign o_req_valid = emit;
    assign o_req       = req;
    assign acc_sh      = {r_acc[20:0], i_byte[6:0]};
    assign tsum        = SUM_BITS'(r_tick) + SUM_BITS'(acc_sh);
    assign row8        = {1'b0, i_key_top} - {1'b0, r_note};

    always_comb begin
        case (r_cnt[1:0])
            2'd0:    ref_b = 8'h4d;
            2'd1:    ref_b = 8'h54;
            2'd2:    ref_b = (r_state == ST_HDR_TAG) ? 8'h68 : 8'h72;
            default: ref_b = (r_state == ST_HDR_TAG) ? 8'h64 : 8'h6b;
        endcase
    end

    always_comb begin
        n_state = r_state; n_cnt = r_cnt; n_acc = r_acc; n_div = r_div;
        n_tick = r_tick; n_ntrk = r_ntrk; n_tdone = r_tdone; n_note = r_note;
        n_evk = r_evk; n_stop = r_stop;
        emit = 1'b0;
        req = '0;
        req.track = r_tdone;
        req.steps = i_steps;
        req.division = r_div;
        req.ticks = 40'(r_tick);
        if (i_valid && o_ready && !r_stop) begin
            case (r_state)
                ST_HDR_TAG, ST_TRK_TAG: begin
                    if (i_byte != ref_b) begin
                        emit = 1'b1; req.kind = KIND_ERROR;
                        req.code = (r_state == ST_HDR_TAG) ? ERR_HDR_TAG : ERR_TRK_TAG;
                    end else if (r_cnt == 3'd3) begin
                        n_cnt = '0;
                        n_state = (r_state == ST_HDR_TAG) ? ST_HDR_LEN : ST_TRK_LEN;
                    end else n_cnt = r_cnt + 3'd1;
                end
                ST_HDR_LEN: begin
                    if (i_byte != ((r_cnt == 3'd3) ? 8'h06 : 8'h00)) begin
                        emit = 1'b1; req.kind = KIND_ERROR; req.code = ERR_HDR_LEN;
                    end else if (r_cnt == 3'd3) begin
                        n_cnt = '0; n_state = ST_HDR_FMT;
                    end else n_cnt = r_cnt + 3'd1;
                end
                ST_HDR_FMT: begin
                    if ((r_cnt == 3'd0 && i_byte != 8'd0) || (r_cnt != 3'd0 && i_byte > 8'd2)) begin
                        emit = 1'b1; req.kind = KIND_ERROR; req.code = ERR_FORMAT;
                    end else if (r_cnt != 3'd0) begin
                        n_cnt = '0; n_state = ST_HDR_NTRK;
                    end else n_cnt = 3'd1;
                end
                ST_HDR_NTRK: begin
                    if (r_cnt == 3'd0) begin
                        if (i_byte != 8'd0) begin
                            emit = 1'b1; req.kind = KIND_ERROR; req.code = ERR_NTRK;
                        end else n_cnt = 3'd1;
                    end else begin
                        n_ntrk = i_byte; n_cnt = '0; n_state = ST_HDR_DIV;
                    end
                end
                ST_HDR_DIV: begin
                    if (r_cnt == 3'd0) begin
                        n_div = {i_byte, 8'd0}; n_cnt = 3'd1;
                    end else begin
                        n_div = {r_div[15:8], i_byte}; n_cnt = '0;
                        if (n_div == 16'd0) begin
                            emit = 1'b1; req.kind = KIND_ERROR; req.code = ERR_ZERO_DIV;
                        end else if (r_ntrk == 8'd0) begin
                            emit = 1'b1; req.kind = KIND_DONE; n_stop = 1'b1;
                        end else n_state = ST_TRK_TAG;
                    end
                end
                ST_TRK_LEN: begin
                    if (r_cnt == 3'd3) begin
                        n_tick = '0; n_evk = '0; n_acc = '0; n_cnt = '0;
                        n_state = ST_DELTA;
                    end else n_cnt = r_cnt + 3'd1;
                end
                ST_DELTA: begin
                    n_acc = acc_sh; n_cnt = r_cnt + 3'd1;
                    if (i_byte[7]) begin
                        if (r_cnt >= 3'd3) begin
                            emit = 1'b1; req.kind = KIND_ERROR; req.code = ERR_LONG;
                        end
                    end else begin
                        n_tick = (tsum > SUM_BITS'(TMAX)) ? TMAX : tsum[TICK_BITS-1:0];
                        n_state = ST_STATUS;
                    end
                end
                ST_STATUS, ST_DATA1: begin
                    if (r_state == ST_DATA1 || i_byte < 8'h80) begin
                        if (r_state == ST_STATUS && r_evk == 4'd0) begin
                            emit = 1'b1; req.kind = KIND_ERROR; req.code = ERR_STATUS;
                        end else begin
                            case (r_evk)
                                4'h9: begin
                                    if (!i_byte[7]) begin
                                        n_note = i_byte[6:0]; n_state = ST_NOTE_VEL;
                                    end else n_state = ST_VEL_CHK;
                                end
                                4'h8: n_state = ST_VEL_CHK;
                                4'hc, 4'hd: begin
                                    n_acc = '0; n_cnt = '0; n_state = ST_DELTA;
                                end
                                default: n_state = ST_SKIP1;
                            endcase
                        end
                    end else if (i_byte < 8'hf0) begin
                        n_evk = i_byte[7:4]; n_state = ST_DATA1;
                    end else if (i_byte == 8'hf0 || i_byte == 8'hf7) begin
                        n_evk = '0; n_acc = '0; n_cnt = '0; n_state = ST_LEN;
                    end else if (i_byte == 8'hff) begin
                        n_evk = '0; n_state = ST_META;
                    end else begin
                        emit = 1'b1; req.kind = KIND_ERROR; req.code = ERR_STATUS;
                    end
                end
                ST_NOTE_VEL: begin
                    if (i_byte[7]) begin
                        emit = 1'b1; req.kind = KIND_ERROR; req.code = ERR_VELOCITY;
                    end else begin
                        n_acc = '0; n_cnt = '0; n_state = ST_DELTA;
                        if (i_byte != 8'd0 && r_note <= i_key_top && row8 < i_row_count) begin
                            emit = 1'b1; req.kind = KIND_NOTE; req.row = row8[6:0];
                        end
                    end
                end
                ST_VEL_CHK: begin
                    if (i_byte[7]) begin
                        emit = 1'b1; req.kind = KIND_ERROR; req.code = ERR_VELOCITY;
                    end else begin
                        n_acc = '0; n_cnt = '0; n_state = ST_DELTA;
                    end
                end
                ST_SKIP1: begin
                    n_acc = '0; n_cnt = '0; n_state = ST_DELTA;
                end
                ST_META: begin
                    if (i_byte == 8'h2f) n_state = ST_EOT_LEN;
                    else if (i_byte <= 8'h09 || i_byte == 8'h20 || i_byte == 8'h21 ||
                             i_byte == 8'h51 || i_byte == 8'h54 || i_byte == 8'h58 ||
                             i_byte == 8'h59 || i_byte == 8'h7f) begin
                        n_acc = '0; n_cnt = '0; n_state = ST_LEN;
                    end else begin
                        emit = 1'b1; req.kind = KIND_ERROR; req.code = ERR_META;
                    end
                end
                ST_EOT_LEN: begin
                    if (i_byte != 8'd0) begin
                        emit = 1'b1; req.kind = KIND_ERROR; req.code = ERR_EOT;
                    end else begin
                        n_tdone = r_tdone + 8'd1;
                        req.track = n_tdone;
                        if (n_tdone == r_ntrk) begin
                            emit = 1'b1; req.kind = KIND_DONE; n_stop = 1'b1;
                        end else begin
                            n_cnt = '0; n_state = ST_TRK_TAG;
                        end
                    end
                end
                ST_LEN: begin
                    n_acc = acc_sh; n_cnt = r_cnt + 3'd1;
                    if (i_byte[7]) begin
                        if (r_cnt >= 3'd3) begin
                            emit = 1'b1; req.kind = KIND_ERROR; req.code = ERR_LONG;
                        end
                    end else if (acc_sh == 28'd0) begin
                        n_cnt = '0; n_state = ST_DELTA;
                    end else n_state = ST_SKIP;
                end
                ST_SKIP: begin
                    n_acc = r_acc - 28'd1;
                    if (r_acc <= 28'd1) begin
                        n_acc = '0; n_cnt = '0; n_state = ST_DELTA;
                    end
                end
                default: n_state = ST_HDR_TAG;
            endcase
            if (emit && req.kind == KIND_ERROR) n_stop = 1'b1;
            if (i_last && !(emit && req.kind != KIND_NOTE)) begin
                emit = 1'b1; req.kind = KIND_ERROR; req.code = ERR_TRUNCATED;
                req.row = '0; n_stop = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_HDR_TAG; r_cnt <= '0; r_acc <= '0; r_div <= '0;
            r_tick <= '0; r_ntrk <= '0; r_tdone <= '0; r_note <= '0;
            r_evk <= '0; r_stop <= 1'b0;
        end else begin
            r_state <= n_state; r_cnt <= n_cnt; r_acc <= n_acc; r_div <= n_div;
            r_tick <= n_tick; r_ntrk <= n_ntrk; r_tdone <= n_tdone; r_note <= n_note;
            r_evk <= n_evk; r_stop <= n_stop;
        end
    end

endmodule

/* rtl/mngp_queue.sv */
// two-entry request queue between parser and result unit
// depends on mngp_pkg
`timescale 1ns / 1ps
module mngp_queue
    import mngp_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_req i_data,
    output logic o_valid,
    input  logic i_ready,
    output t_req o_data
);

    t_req       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       wr, rd;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rp];
    assign wr      = i_valid && o_ready;
    assign rd      = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (wr) r_mem[r_wp] <= i_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= '0;
        end else begin
            if (wr) r_wp <= ~r_wp;
            if (rd) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, wr} - {1'b0, rd};
        end
    end

endmodule

/* rtl/mngp_back.sv */
// result unit: column = steps*ticks/division by restoring division, saturated
// depends on mngp_pkg
`timescale 1ns / 1ps
module mngp_back
    import mngp_pkg::*;
#(
    parameter int COLUMN_BITS = 16,
    parameter int TICK_BITS   = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_req        i_req,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_kind,
    output logic [6:0]  o_row,
    output logic [15:0] o_col,
    output logic [7:0]  o_track,
    output logic [3:0]  o_code
);

    localparam int NB = TICK_BITS + 5;
    localparam int CW = $clog2(NB + 1);
    localparam int QW = (NB > COLUMN_BITS) ? NB : COLUMN_BITS;

    typedef enum logic [2:0] {
        BS_IDLE = 3'b001,
        BS_DIV  = 3'b010,
        BS_OUT  = 3'b100
    } t_bstate;

    t_bstate r_st;
    t_req    r_req;
    logic [NB-1:0] r_num;
    logic [NB-1:0] r_quo;
    logic [16:0]   r_rem;
    logic [CW-1:0] r_cnt;
    logic [16:0]   rem_sh;
    logic [QW-1:0] colv;
    logic [COLUMN_BITS-1:0] colsat;

    assign o_ready = (r_st == BS_IDLE);
    assign o_valid = (r_st == BS_OUT);
    assign rem_sh  = {r_rem[15:0], r_num[NB-1]};
    assign colv    = QW'(r_quo);
    assign colsat  = (colv > QW'({COLUMN_BITS{1'b1}})) ? '1 : colv[COLUMN_BITS-1:0];
    assign o_kind  = r_req.kind;
    assign o_row   = r_req.row;
    assign o_track = r_req.track;
    assign o_code  = r_req.code;
    assign o_col   = (r_req.kind == KIND_NOTE) ? 16'(colsat) : 16'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= BS_IDLE;
        end else begin
            case (r_st)
                BS_IDLE: begin
                    if (i_valid) begin
                        r_req <= i_req;
                        r_num <= NB'(i_req.ticks[TICK_BITS-1:0]) * NB'(i_req.steps);
                        r_quo <= '0;
                        r_rem <= '0;
                        r_cnt <= CW'(NB);
                        r_st  <= (i_req.kind == KIND_NOTE) ? BS_DIV : BS_OUT;
                    end
                end
                BS_DIV: begin
                    r_num <= {r_num[NB-2:0], 1'b0};
                    if (rem_sh >= {1'b0, r_req.division}) begin
                        r_rem <= rem_sh - {1'b0, r_req.division};
                        r_quo <= {r_quo[NB-2:0], 1'b1};
                    end else begin
                        r_rem <= rem_sh;
                        r_quo <= {r_quo[NB-2:0], 1'b0};
                    end
                    r_cnt <= r_cnt - CW'(1);
                    if (r_cnt == CW'(1)) r_st <= BS_OUT;
                end
                BS_OUT: if (i_ready) r_st <= BS_IDLE;
                default: r_st <= BS_IDLE;
            endcase
        end
    end

endmodule
